[hdl/mmts_pkg.sv]
package mmts_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int ADDR_WIDTH = 16;
  localparam int BIT_W      = $clog2(DATA_WIDTH);
  localparam int CNT_W      = ADDR_WIDTH + 1;
  localparam int WC_W       = 17;
  localparam int BASE_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // march element codes
  localparam logic [2:0] EL_IDLE    = 3'd0;
  localparam logic [2:0] EL_W0_UP   = 3'd1;
  localparam logic [2:0] EL_R0W1_UP = 3'd2;
  localparam logic [2:0] EL_R1W0_DN = 3'd3;
  localparam logic [2:0] EL_R0W1_DN = 3'd4;
  localparam logic [2:0] EL_R1W0_UP = 3'd5;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic FAULT_READ_ONE  = 1'b0;
  localparam logic FAULT_READ_ZERO = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT   = 8'd1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] mem_address;
    logic        mem_read;
    logic        mem_write;
    logic [63:0] mem_write_data;
    logic        busy_res;
    logic        done_res;
    logic        passed;
    logic [15:0] fail_address;
    logic        fail_type;
  } out_item_t;

endpackage

[hdl/march_memory_test_sequencer.sv]
// March C- style memory self-test sequencer (bit-oriented, five elements).
// Each transfer on the input channel is one step: cmd 0 starts a test, cmd 1
// advances it, carrying the word read on the previous step. Each step yields
// exactly one result transfer with the memory access to issue and the test
// status. Steps are accepted one per clock: the step logic sits between an
// input register and a result register, so an item passes through both
// registers before it is returned, and the rate is one item per cycle while
// the result side does not stall. Configuration (base_address, word_count) is written through
// the cfg port, which is always ready.
module march_memory_test_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mmts_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mmts_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mmts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mmts_pkg::*;

  logic      take;
  logic      item_valid;
  in_item_t  item;
  out_item_t res;

  assign cfg_ready = 1'b1;

  mmts_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  mmts_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (take),
    .item      (item),
    .res       (res)
  );

  mmts_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[hdl/mmts_in_stage.sv]
module mmts_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mmts_pkg::in_item_t in_data,
  input  logic               take,
  output logic               item_valid,
  output mmts_pkg::in_item_t item
);
  import mmts_pkg::*;

  logic     valid_r;
  in_item_t item_r;
  logic     load;

  // hold the item until the engine takes it
  assign in_stall   = valid_r && !take;
  assign load       = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

endmodule

[hdl/mmts_engine.sv]
module mmts_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mmts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          fire,
  input  mmts_pkg::in_item_t            item,
  output mmts_pkg::out_item_t           res
);
  import mmts_pkg::*;

  localparam int TW = 34;

  logic [BASE_W-1:0]     base_r;
  logic [WC_W-1:0]       count_r;
  logic [2:0]            elem_r, elem_nxt;
  logic [CNT_W-1:0]      wp_r, wp_nxt;
  logic [BIT_W-1:0]      bp_r, bp_nxt;
  logic                  rp_r, rp_nxt;
  logic                  fin_r, fin_nxt;
  logic                  pass_r, pass_nxt;
  logic [ADDR_WIDTH-1:0] faddr_r, faddr_nxt;
  logic                  fkind_r, fkind_nxt;

  logic [TW-1:0]         wc_t, lim_t;
  logic [CNT_W-1:0]      cnt, idx;
  logic [CNT_W:0]        wp_inc;
  logic                  last_word, up, top_down, want_one, is_one;
  logic [ADDR_WIDTH-1:0] addr;
  logic [BIT_W-1:0]      bsel;
  logic [DATA_WIDTH-1:0] bitv, data, wdata;
  logic [ADDR_WIDTH-1:0] o_addr;
  logic                  o_rd, o_wr;

  assign wc_t      = TW'(count_r);
  assign lim_t     = TW'(1) << ADDR_WIDTH;
  assign cnt       = CNT_W'((wc_t > lim_t) ? lim_t : wc_t);
  assign wp_inc    = {1'b0, wp_r} + 1'b1;
  assign last_word = wp_inc >= {1'b0, cnt};
  assign up        = (elem_r == EL_W0_UP) || (elem_r == EL_R0W1_UP) || (elem_r == EL_R1W0_UP);
  assign top_down  = (elem_r == EL_R0W1_UP) || (elem_r == EL_R1W0_UP);
  assign want_one  = (elem_r == EL_R1W0_DN) || (elem_r == EL_R1W0_UP);
  assign idx       = up ? wp_r : (cnt - 1'b1 - wp_r);
  assign addr      = ADDR_WIDTH'(CNT_W'(base_r) + idx);
  assign bsel      = top_down ? BIT_W'(DATA_WIDTH - 1) - bp_r : bp_r;
  assign bitv      = DATA_WIDTH'(1) << bsel;
  assign data      = item.read_data[DATA_WIDTH-1:0];
  assign is_one    = (data & bitv) != '0;

  always_comb begin
    elem_nxt  = elem_r;
    wp_nxt    = wp_r;
    bp_nxt    = bp_r;
    rp_nxt    = rp_r;
    fin_nxt   = fin_r;
    pass_nxt  = pass_r;
    faddr_nxt = faddr_r;
    fkind_nxt = fkind_r;
    o_addr    = '0;
    o_rd      = 1'b0;
    o_wr      = 1'b0;
    wdata     = '0;
    if (item.cmd == CMD_START) begin
      wp_nxt    = '0;
      bp_nxt    = '0;
      rp_nxt    = 1'b0;
      faddr_nxt = '0;
      fkind_nxt = 1'b0;
      if (cnt == '0) begin
        elem_nxt = EL_IDLE;
        fin_nxt  = 1'b1;
        pass_nxt = 1'b1;
      end else begin
        elem_nxt = EL_W0_UP;
        fin_nxt  = 1'b0;
        pass_nxt = 1'b0;
      end
    end else if (elem_r >= EL_W0_UP && elem_r <= EL_R1W0_UP) begin
      if (elem_r == EL_W0_UP) begin
        o_addr = addr;
        o_wr   = 1'b1;
        bp_nxt = '0;
        if (last_word) begin
          wp_nxt   = '0;
          elem_nxt = elem_r + 3'd1;
        end else begin
          wp_nxt = wp_inc[CNT_W-1:0];
        end
      end else if (!rp_r) begin
        o_addr = addr;
        o_rd   = 1'b1;
        rp_nxt = 1'b1;
      end else begin
        rp_nxt = 1'b0;
        if (is_one != want_one) begin
          faddr_nxt = addr;
          fkind_nxt = want_one ? FAULT_READ_ZERO : FAULT_READ_ONE;
          elem_nxt  = EL_IDLE;
          fin_nxt   = 1'b1;
          pass_nxt  = 1'b0;
        end else begin
          o_addr = addr;
          o_wr   = 1'b1;
          wdata  = want_one ? (data & ~bitv) : (data | bitv);
          if (bp_r == BIT_W'(DATA_WIDTH - 1)) begin
            // last bit of the word: move to the next word or element
            bp_nxt = '0;
            if (last_word) begin
              wp_nxt = '0;
              if (elem_r == EL_R1W0_UP) begin
                elem_nxt = EL_IDLE;
                fin_nxt  = 1'b1;
                pass_nxt = 1'b1;
              end else begin
                elem_nxt = elem_r + 3'd1;
              end
            end else begin
              wp_nxt = wp_inc[CNT_W-1:0];
            end
          end else begin
            bp_nxt = bp_r + 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    res.mem_address    = 16'(o_addr);
    res.mem_read       = o_rd;
    res.mem_write      = o_wr;
    res.mem_write_data = 64'(wdata);
    res.busy_res       = elem_nxt != EL_IDLE;
    res.done_res       = fin_nxt;
    res.passed         = fin_nxt && pass_nxt;
    res.fail_address   = 16'(faddr_nxt);
    res.fail_type      = fkind_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_BASE_ADDRESS) begin
        base_r <= cfg_data[BASE_W-1:0];
      end else if (cfg_index == REG_WORD_COUNT) begin
        count_r <= cfg_data[WC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_r  <= EL_IDLE;
      wp_r    <= '0;
      bp_r    <= '0;
      rp_r    <= 1'b0;
      fin_r   <= 1'b0;
      pass_r  <= 1'b0;
      faddr_r <= '0;
      fkind_r <= 1'b0;
    end else if (fire) begin
      elem_r  <= elem_nxt;
      wp_r    <= wp_nxt;
      bp_r    <= bp_nxt;
      rp_r    <= rp_nxt;
      fin_r   <= fin_nxt;
      pass_r  <= pass_nxt;
      faddr_r <= faddr_nxt;
      fkind_r <= fkind_nxt;
    end
  end

endmodule

[hdl/mmts_out_stage.sv]
module mmts_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  mmts_pkg::out_item_t res,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output mmts_pkg::out_item_t out_data
);
  import mmts_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  // accept a new result whenever the register is empty or drains this cycle
  assign take      = item_valid && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= res;
    end
  end

endmodule

[hdl/mmts_checker.sv]
module mmts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input mmts_pkg::out_item_t out_data
);
  import mmts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.mem_read && out_data.mem_write))
    else $error("read and write issued together");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mem_read |-> out_data.busy_res && !out_data.done_res)
    else $error("read issued outside a running test");

  a_pass_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.passed |-> out_data.done_res && !out_data.busy_res)
    else $error("pass reported before the test finished");

endmodule

bind march_memory_test_sequencer mmts_checker u_mmts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[sim/march_sequencer_checker.sv]
`timescale 1ns / 100ps

module march_sequencer_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  mmts_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  mmts_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mmts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmts_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     error_count,
  output int unsigned                     outstanding
);
  import mmts_pkg::*;

  localparam int unsigned WORD_LIMIT = 1 << ADDR_WIDTH;

  logic [BASE_W-1:0]     base_reg;
  logic [WC_W-1:0]       count_reg;
  logic [2:0]            element;
  int unsigned           word_ptr;
  int unsigned           bit_ptr;
  bit                    read_pending;
  bit                    finished;
  bit                    pass_ok;
  logic [ADDR_WIDTH-1:0] fault_addr;
  logic                  fault_kind;
  out_item_t             step_results_q[$];
  int unsigned           result_num;

  function automatic int unsigned live_count();
    return (count_reg > WORD_LIMIT) ? WORD_LIMIT : int'(count_reg);
  endfunction

  function automatic void end_test(bit ok);
    element      = EL_IDLE;
    finished     = 1'b1;
    pass_ok      = ok;
    read_pending = 1'b0;
  endfunction

  // step to the next word; past the last word move on to the next element, or end the test after the last one
  function automatic void next_word();
    bit_ptr = 0;
    if (word_ptr + 1 >= live_count()) begin
      word_ptr = 0;
      if (element >= EL_R1W0_UP)
        end_test(1'b1);
      else
        element = element + 3'd1;
    end else begin
      word_ptr++;
    end
  endfunction

  function automatic out_item_t advance_march(in_item_t it);
    out_item_t             r;
    logic [31:0]           idx;
    logic [ADDR_WIDTH-1:0] addr;
    logic [63:0]           bit_mask;
    int unsigned           bit_pos;
    bit                    up;
    bit                    top_down;
    bit                    want_one;
    bit                    is_one;
    r = '0;
    if (it.cmd == CMD_START) begin
      word_ptr     = 0;
      bit_ptr      = 0;
      read_pending = 1'b0;
      finished     = 1'b0;
      pass_ok      = 1'b0;
      fault_addr   = '0;
      fault_kind   = FAULT_READ_ONE;
      element      = EL_W0_UP;
      if (live_count() == 0) end_test(1'b1);
    end else if (element != EL_IDLE) begin
      up   = (element == EL_W0_UP) || (element == EL_R0W1_UP) || (element == EL_R1W0_UP);
      idx  = up ? word_ptr : live_count() - 1 - word_ptr;
      addr = base_reg + idx[ADDR_WIDTH-1:0];
      if (element == EL_W0_UP) begin
        r.mem_address = addr;
        r.mem_write   = 1'b1;
        next_word();
      end else if (!read_pending) begin
        r.mem_address = addr;
        r.mem_read    = 1'b1;
        read_pending  = 1'b1;
      end else begin
        top_down = (element == EL_R0W1_UP) || (element == EL_R1W0_UP);
        want_one = (element == EL_R1W0_DN) || (element == EL_R1W0_UP);
        bit_pos  = top_down ? DATA_WIDTH - 1 - bit_ptr : bit_ptr;
        bit_mask = 64'd1 << bit_pos;
        is_one   = |(it.read_data & bit_mask);
        read_pending = 1'b0;
        if (is_one != want_one) begin
          fault_addr = addr;
          fault_kind = want_one ? FAULT_READ_ZERO : FAULT_READ_ONE;
          end_test(1'b0);
        end else begin
          r.mem_address    = addr;
          r.mem_write      = 1'b1;
          r.mem_write_data = want_one ? (it.read_data & ~bit_mask)
                                      : (it.read_data | bit_mask);
          if (bit_ptr + 1 >= DATA_WIDTH)
            next_word();
          else
            bit_ptr++;
        end
      end
    end
    r.busy_res     = (element != EL_IDLE);
    r.done_res     = finished;
    r.passed       = finished && pass_ok;
    r.fail_address = fault_addr;
    r.fail_type    = fault_kind;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got,
                             inout bit bad);
    if (want !== got) begin
      bad = 1'b1;
      if (error_count < 10)
        $display("result %0d: %s expected %h, got %h", result_num, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    out_item_t want;
    bit        bad;
    if (!rst_n) begin
      base_reg     = '0;
      count_reg    = '0;
      element      = EL_IDLE;
      word_ptr     = 0;
      bit_ptr      = 0;
      read_pending = 1'b0;
      finished     = 1'b0;
      pass_ok      = 1'b0;
      fault_addr   = '0;
      fault_kind   = FAULT_READ_ONE;
      result_num   = 0;
      error_count  = 0;
      step_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_ADDRESS: base_reg  = cfg_data[BASE_W-1:0];
          REG_WORD_COUNT:   count_reg = cfg_data[WC_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (step_results_q.size() == 0) begin
          if (error_count < 10)
            $display("result %0d: transfer with no step outstanding", result_num);
          error_count++;
        end else begin
          want = step_results_q.pop_front();
          bad  = 1'b0;
          check_field("mem_address", 64'(want.mem_address), 64'(out_data.mem_address), bad);
          check_field("mem_read", 64'(want.mem_read), 64'(out_data.mem_read), bad);
          check_field("mem_write", 64'(want.mem_write), 64'(out_data.mem_write), bad);
          check_field("mem_write_data", want.mem_write_data, out_data.mem_write_data, bad);
          check_field("busy_res", 64'(want.busy_res), 64'(out_data.busy_res), bad);
          check_field("done_res", 64'(want.done_res), 64'(out_data.done_res), bad);
          check_field("passed", 64'(want.passed), 64'(out_data.passed), bad);
          check_field("fail_address", 64'(want.fail_address), 64'(out_data.fail_address),
                      bad);
          check_field("fail_type", 64'(want.fail_type), 64'(out_data.fail_type), bad);
          if (bad) error_count++;
        end
        result_num++;
      end
      if (in_valid && !in_stall)
        step_results_q.push_back(advance_march(in_data));
    end
    outstanding = step_results_q.size();
  end

endmodule

[sim/march_memory_test_sequencer_tb.sv]
`timescale 1ns / 100ps

module march_memory_test_sequencer_tb;
  import mmts_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 950;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           error_count;
  int unsigned           outstanding;

  // memory behind the sequencer, fed by the write accesses it issues
  bit [63:0]             mem_model [65536];
  bit                    last_read;
  bit                    last_done;
  logic [15:0]           last_addr;
  int unsigned           sent_count;
  int unsigned           recv_count;
  int unsigned           rand_base;
  bit                    random_phase;
  int unsigned           in_idle_pct;
  int unsigned           out_stall_pct;
  int unsigned           read_checks;
  int unsigned           fault_at;
  bit                    bit_noise;

  march_memory_test_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  march_sequencer_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("march_memory_test_sequencer_tb: errors");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (random_phase) begin
      if (sent_count - rand_base < RANDOM_ITEMS / 3) begin
        in_idle_pct   = 8;
        out_stall_pct = 60;
      end else if (sent_count - rand_base < 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct   = 60;
        out_stall_pct = 8;
      end else begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (out_data.mem_write) mem_model[out_data.mem_address] = out_data.mem_write_data;
      last_read = out_data.mem_read;
      last_addr = out_data.mem_address;
      last_done = out_data.done_res;
      recv_count++;
    end
  end

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // drop valid and hold until every step has returned its result
  task automatic settle_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (recv_count != sent_count) @(posedge clk);
  endtask

  task automatic reg_update(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle_results();
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one step that answers the previous read from the memory model
  task automatic issue(input logic cmd);
    in_item_t it;
    settle_results();
    it.cmd       = cmd;
    it.read_data = {$urandom, $urandom};
    if (cmd == CMD_START) begin
      read_checks = 0;
    end else if (last_read) begin
      read_checks++;
      it.read_data = mem_model[last_addr];
      if (read_checks == fault_at) it.read_data = ~it.read_data;
      if (bit_noise && $urandom_range(149) == 0)
        it.read_data[$urandom_range(63)] ^= 1'b1;
    end
    send_item(it);
  endtask

  initial begin : stimulus
    in_item_t    noise_item;
    int unsigned steps;
    int unsigned max_steps;
    int unsigned end_count;
    int unsigned pick;
    logic [16:0] count_val;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    sent_count    = 0;
    recv_count    = 0;
    rand_base     = 0;
    random_phase  = 1'b0;
    in_idle_pct   = 8;
    out_stall_pct = 60;
    read_checks   = 0;
    fault_at      = 0;
    bit_noise     = 1'b0;
    last_read     = 1'b0;
    last_done     = 1'b0;
    last_addr     = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // advance with no test armed
    issue(CMD_STEP);
    // empty region passes at once
    reg_update(REG_WORD_COUNT, 32'd0);
    reg_update(REG_BASE_ADDRESS, 32'h0000_1234);
    issue(CMD_START);
    issue(CMD_STEP);
    // unknown index is ignored; region wraps past the top address and the
    // first read comes back inverted
    reg_update(REG_UNUSED, $urandom);
    reg_update(REG_BASE_ADDRESS, 32'hA5A5_FFFF);
    reg_update(REG_WORD_COUNT, 32'd2);
    fault_at = 1;
    issue(CMD_START);
    repeat (4) issue(CMD_STEP);
    fault_at = 0;
    // oversized count saturates; restart while running
    reg_update(REG_WORD_COUNT, 32'hFFFF_FFFF);
    issue(CMD_START);
    repeat (3) issue(CMD_STEP);
    issue(CMD_START);
    repeat (2) issue(CMD_STEP);
    // shrink the region while the first element is under way
    reg_update(REG_BASE_ADDRESS, 32'h0000_0010);
    reg_update(REG_WORD_COUNT, 32'd3);
    issue(CMD_START);
    repeat (2) issue(CMD_STEP);
    reg_update(REG_WORD_COUNT, 32'd1);
    repeat (3) issue(CMD_STEP);

    rand_base    = sent_count;
    end_count    = sent_count + RANDOM_ITEMS;
    random_phase = 1'b1;
    while (sent_count < end_count) begin
      if ($urandom_range(1) == 0) begin
        pick = $urandom_range(99);
        reg_update(REG_BASE_ADDRESS, pick < 15 ? {16'($urandom_range(65535)), 16'h0000} :
                                     pick < 30 ? 32'h0000_FFFF : $urandom);
      end
      pick = $urandom_range(99);
      if (pick < 4)       count_val = 17'd0;
      else if (pick < 8)  count_val = 17'd65536;
      else if (pick < 11) count_val = 17'($urandom_range(65537, 131071));
      else if (pick < 14) count_val = 17'($urandom_range(4, 65535));
      else if (pick < 75) count_val = 17'd1;
      else                count_val = 17'($urandom_range(2, 3));
      if ($urandom_range(2) != 0)
        reg_update(REG_WORD_COUNT, ($urandom & 32'hFFFE_0000) | 32'(count_val));

      if ($urandom_range(9) < 2) begin
        // back-to-back noise with random commands and read words
        settle_results();
        repeat ($urandom_range(5, 30)) begin
          noise_item.cmd = ($urandom_range(15) == 0) ? CMD_START : CMD_STEP;
          pick = $urandom_range(7);
          noise_item.read_data = (pick == 0) ? 64'd0 :
                                 (pick == 1) ? ~64'd0 : {$urandom, $urandom};
          send_item(noise_item);
        end
      end else begin
        fault_at  = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 260);
        bit_noise = ($urandom_range(3) == 0);
        max_steps = (count_val <= 3) ? 100000 : $urandom_range(5, 40);
        steps     = 0;
        issue(CMD_START);
        forever begin
          settle_results();
          if (last_done || steps >= max_steps || sent_count >= end_count) break;
          issue(($urandom_range(399) == 0) ? CMD_START : CMD_STEP);
          steps++;
        end
        if (last_done) repeat ($urandom_range(2)) issue(CMD_STEP);
      end
    end

    settle_results();
    repeat (10) @(posedge clk);
    if (error_count == 0 && outstanding == 0)
      $display("march_memory_test_sequencer_tb: clean");
    else
      $display("march_memory_test_sequencer_tb: errors");
    $finish;
  end

endmodule
